// ----- src/tmf_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and register indexes for the temporal median filter.
// Depends on nothing; every other file imports it.
package tmf_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int MAX_HISTORY = 16;
    localparam int SAMPLE_BITS = 16;

    localparam int POS_W   = $clog2(MAX_POINTS);
    localparam int SLOT_W  = $clog2(MAX_HISTORY);
    localparam int LEN_W   = 11;
    localparam int DEPTH_W = 5;
    localparam int SORT_N  = MAX_HISTORY + 1;
    localparam int CNT_W   = $clog2(SORT_N + 1);
    localparam int ADDR_W  = SLOT_W + POS_W;

    localparam logic REG_SCAN_LENGTH   = 1'b0;
    localparam logic REG_HISTORY_DEPTH = 1'b1;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_idx;
        logic              commit;
    } t_hist_cmd;

    typedef struct packed {
        logic [DEPTH_W-1:0] stored;
        logic               last;
    } t_hist_stat;

endpackage

// ----- src/tmf_cfg.sv -----
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port, with range clamping.
// Depends on tmf_pkg.
module tmf_cfg
    import tmf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [LEN_W-1:0]   o_len,
    output logic [DEPTH_W-1:0] o_depth
);

    logic [LEN_W-1:0]   r_scan_length;
    logic [DEPTH_W-1:0] r_history_depth;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_length   <= LEN_W'(MAX_POINTS);
            r_history_depth <= DEPTH_W'(3);
        end else if (wr_en) begin
            case (paddr[2])
                REG_SCAN_LENGTH: begin
                    r_scan_length <= pwdata[LEN_W-1:0];
                end
                REG_HISTORY_DEPTH: begin
                    r_history_depth <= pwdata[DEPTH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SCAN_LENGTH:   prdata = 32'(r_scan_length);
            REG_HISTORY_DEPTH: prdata = 32'(r_history_depth);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        if (r_scan_length == '0) begin
            o_len = LEN_W'(1);
        end else if (r_scan_length > LEN_W'(MAX_POINTS)) begin
            o_len = LEN_W'(MAX_POINTS);
        end else begin
            o_len = r_scan_length;
        end
        if (r_history_depth > DEPTH_W'(MAX_HISTORY)) begin
            o_depth = DEPTH_W'(MAX_HISTORY);
        end else begin
            o_depth = r_history_depth;
        end
    end

endmodule

// ----- src/tmf_history.sv -----
`timescale 1ns / 1ps
// History ring: the scan memory, the ring pointers and the in-scan position.
// Depends on tmf_pkg.
module tmf_history
    import tmf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_hist_cmd          i_cmd,
    input  t_sample            i_cur,
    input  logic [LEN_W-1:0]   i_len,
    input  logic [DEPTH_W-1:0] i_depth,
    output t_sample            o_rd_data,
    output t_hist_stat         o_stat
);

    t_sample            r_mem [0:MAX_HISTORY*MAX_POINTS-1];
    t_sample            r_rd_data;
    logic [DEPTH_W-1:0] r_stored;
    logic [SLOT_W-1:0]  r_oldest;
    logic [POS_W-1:0]   r_position;

    logic [SLOT_W-1:0]  rd_slot;
    logic [SLOT_W-1:0]  wr_slot;
    logic               growing;
    logic               last;

    assign rd_slot = r_oldest + i_cmd.rd_idx;
    assign growing = r_stored < i_depth;
    assign wr_slot = growing ? r_oldest + r_stored[SLOT_W-1:0] : r_oldest;
    assign last    = ({1'b0, r_position} + LEN_W'(1)) >= i_len;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[{rd_slot, r_position}];
        end
        if (i_cmd.commit) begin
            r_mem[{wr_slot, r_position}] <= i_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored   <= '0;
            r_oldest   <= '0;
            r_position <= '0;
        end else if (i_cmd.commit) begin
            if (last) begin
                if (growing) begin
                    r_stored <= r_stored + DEPTH_W'(1);
                end else begin
                    r_oldest <= r_oldest + SLOT_W'(1);
                end
                r_position <= '0;
            end else begin
                r_position <= r_position + POS_W'(1);
            end
        end
    end

    assign o_rd_data     = r_rd_data;
    assign o_stat.stored = r_stored;
    assign o_stat.last   = last;

endmodule

// ----- src/tmf_sorter.sv -----
`timescale 1ns / 1ps
// Insertion unit: keeps the gathered values in ascending order, one insert a cycle.
// Depends on tmf_pkg.
module tmf_sorter
    import tmf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_insert,
    input  t_sample           i_value,
    input  logic [CNT_W-1:0]  i_sel_idx,
    output t_sample           o_sel
);

    t_sample          r_vals [0:SORT_N-1];
    t_sample          n_vals [0:SORT_N-1];
    logic [CNT_W-1:0] r_num;
    logic [SORT_N-1:0] keep;

    always_comb begin
        for (int j = 0; j < SORT_N; j++) begin
            keep[j] = (CNT_W'(j) < r_num) && (r_vals[j] <= i_value);
        end
        for (int j = 0; j < SORT_N; j++) begin
            if (keep[j]) begin
                n_vals[j] = r_vals[j];
            end else if (j == 0) begin
                n_vals[j] = i_value;
            end else if (keep[j-1]) begin
                n_vals[j] = i_value;
            end else begin
                n_vals[j] = r_vals[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vals[0] <= i_value;
        end else if (i_insert) begin
            for (int j = 0; j < SORT_N; j++) begin
                r_vals[j] <= n_vals[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= '0;
        end else if (i_load) begin
            r_num <= CNT_W'(1);
        end else if (i_insert) begin
            r_num <= r_num + CNT_W'(1);
        end
    end

    assign o_sel = r_vals[i_sel_idx];

endmodule

// ----- src/temporal_median_filter_top.sv -----
`timescale 1ns / 1ps
// Top level of the temporal median filter: sequencer, output register and wiring.
// Depends on tmf_pkg, tmf_cfg, tmf_history and tmf_sorter.
//
// Channel   Direction  Handshake                        Payload
// sample    in         i_sample_valid / o_sample_ready  i_sample
// result    out        o_result_valid / i_result_ready  o_filtered, o_end_of_scan
// config    in         psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// A sample goes from acceptance through ST_READ, one history read for each of
// the S stored scans (up to 16), then ST_DRAIN, ST_PICK_LO, ST_PICK_HI and
// ST_OUT, which loads the result; with no stored scans it skips to ST_PICK_LO.
// No new sample is taken until the sequencer is back in ST_IDLE. The pace is set
// by the single history read port, one earlier scan value a cycle to the sorter.
// Reset is synchronous and clears the ring pointers and the sequencer; the
// history memory is not cleared. A stalled result stays in the output register
// and holds the sequencer in its last step until it is taken.
module temporal_median_filter_top
    import tmf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_sample_valid,
    output logic        o_sample_ready,
    input  logic [15:0] i_sample,
    output logic        o_result_valid,
    input  logic        i_result_ready,
    output logic [15:0] o_filtered,
    output logic        o_end_of_scan,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_READ    = 3'd1;
    localparam logic [2:0] ST_DRAIN   = 3'd2;
    localparam logic [2:0] ST_PICK_LO = 3'd3;
    localparam logic [2:0] ST_PICK_HI = 3'd4;
    localparam logic [2:0] ST_OUT     = 3'd5;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    t_sample            r_cur;
    logic [DEPTH_W-1:0] r_issue;
    logic [DEPTH_W-1:0] r_last_idx;
    logic [CNT_W-1:0]   r_total;
    logic               r_rd_pending;
    t_sample            r_lo;
    t_sample            r_hi;
    logic               r_last;
    logic               r_out_valid;
    t_sample            r_filtered;
    logic               r_end_of_scan;

    logic [LEN_W-1:0]   len;
    logic [DEPTH_W-1:0] depth;
    t_hist_cmd          hist_cmd;
    t_hist_stat         hist_stat;
    t_sample            rd_data;
    t_sample            sel;
    logic [CNT_W-1:0]   mid_idx;
    logic [CNT_W-1:0]   sel_idx;
    logic               in_beat;
    logic               out_load;
    logic [SAMPLE_BITS:0] pair_sum;
    t_sample            median;

    tmf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_len   (len),
        .o_depth (depth)
    );

    tmf_history u_history (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (hist_cmd),
        .i_cur     (r_cur),
        .i_len     (len),
        .i_depth   (depth),
        .o_rd_data (rd_data),
        .o_stat    (hist_stat)
    );

    tmf_sorter u_sorter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_beat),
        .i_insert  (r_rd_pending),
        .i_value   (in_beat ? i_sample : rd_data),
        .i_sel_idx (sel_idx),
        .o_sel     (sel)
    );

    assign o_sample_ready = (r_state == ST_IDLE);
    assign in_beat        = i_sample_valid && o_sample_ready;
    assign out_load       = (r_state == ST_OUT) && (!r_out_valid || i_result_ready);

    assign mid_idx = (r_total - CNT_W'(1)) >> 1;
    assign sel_idx = (r_state == ST_PICK_HI) ? mid_idx + CNT_W'(1) : mid_idx;

    assign hist_cmd.rd_en  = (r_state == ST_READ);
    assign hist_cmd.rd_idx = r_issue[SLOT_W-1:0];
    assign hist_cmd.commit = (r_state == ST_PICK_LO);

    assign pair_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign median   = r_total[0] ? r_lo : pair_sum[SAMPLE_BITS:1];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_state = (hist_stat.stored == '0) ? ST_PICK_LO : ST_READ;
                end
            end
            ST_READ: begin
                if (r_issue == r_last_idx) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_PICK_LO;
            end
            ST_PICK_LO: begin
                n_state = ST_PICK_HI;
            end
            ST_PICK_HI: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_rd_pending <= 1'b0;
            r_out_valid  <= 1'b0;
            r_issue      <= '0;
        end else begin
            r_state      <= n_state;
            r_rd_pending <= hist_cmd.rd_en;
            if (in_beat) begin
                r_issue <= '0;
            end else if (hist_cmd.rd_en) begin
                r_issue <= r_issue + DEPTH_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_cur      <= i_sample;
            r_last_idx <= hist_stat.stored - DEPTH_W'(1);
            r_total    <= CNT_W'(hist_stat.stored) + CNT_W'(1);
        end
        if (r_state == ST_PICK_LO) begin
            r_lo   <= sel;
            r_last <= hist_stat.last;
        end
        if (r_state == ST_PICK_HI) begin
            r_hi <= sel;
        end
        if (out_load) begin
            r_filtered    <= median;
            r_end_of_scan <= r_last;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_filtered     = r_filtered;
    assign o_end_of_scan  = r_end_of_scan;

endmodule
